FILE: sv/mscal_pkg.sv
// Shared types, constants and helper functions of the magnetometer scale calibrator.
`default_nettype none

package mscal_pkg;

  // Fixed-point formats.
  localparam int SCALE_FRAC_BITS = 14;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int IN_SAMPLE_W     = 16;
  localparam int EXP_W           = 12;
  localparam int CNT_W           = 6;
  localparam int GAIN_W          = 16;
  localparam int GAIN_FRAC_BITS  = 15;
  localparam int FIELD_FRAC_BITS = 4;
  localparam int FIELD_W         = 21;

  // An accepted ratio stays below 1.35, so it needs SCALE_FRAC_BITS + 1 quotient bits;
  // the count is rounded up to an even number for the two-bit-a-cycle divider.
  localparam int QUOT_W     = 2 * ((SCALE_FRAC_BITS + 2) / 2);
  localparam int SCALE_W    = QUOT_W;
  localparam int SUM_W      = CNT_W + SCALE_W;
  localparam int DIVIDEND_W = EXP_W + SCALE_FRAC_BITS;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_STEPS  = QUOT_W / DIV_BITS_PER_CYCLE;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;

  // Acceptance window 0.7 < e/a < 1.35 as integer cross products.
  localparam int CMP_W      = SAMPLE_WIDTH + 5;
  localparam int RATIO_LO_E = 10;
  localparam int RATIO_LO_A = 7;
  localparam int RATIO_HI_E = 20;
  localparam int RATIO_HI_A = 27;

  // Stream widths.
  localparam int S_TDATA_W  = 3 * IN_SAMPLE_W;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 8 * ((3 * FIELD_W + 7) / 8);
  localparam int M_TUSER_W  = 3;
  localparam int OUT_PAD_W  = M_TDATA_W - 3 * FIELD_W;

  // Register port.
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_EXP_X    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_EXP_YZ   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CAL_SMP  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_MIN_GOOD = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_GAIN     = REG_IDX_W'(4);

  localparam logic [EXP_W-1:0]  EXP_X_RST    = EXP_W'(766);
  localparam logic [EXP_W-1:0]  EXP_YZ_RST   = EXP_W'(713);
  localparam logic [CNT_W-1:0]  CAL_SMP_RST  = CNT_W'(30);
  localparam logic [CNT_W-1:0]  MIN_GOOD_RST = CNT_W'(5);
  localparam logic [GAIN_W-1:0] GAIN_RST     = GAIN_W'(30063);

  typedef struct packed {
    logic [EXP_W-1:0]  exp_x;
    logic [EXP_W-1:0]  exp_yz;
    logic [CNT_W-1:0]  cal_samples;
    logic [CNT_W-1:0]  min_good;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FINISH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_RESULT
  } state_e;

  // Magnitude of the low SAMPLE_WIDTH bits of a raw reading, taken as signed.
  function automatic logic [SAMPLE_WIDTH-1:0] sample_mag(input logic [IN_SAMPLE_W-1:0] s);
    logic [SAMPLE_WIDTH-1:0] v;
    v = s[SAMPLE_WIDTH-1:0];
    return v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // True when the reading is non-zero and e/a lies strictly inside the window.
  function automatic logic ratio_ok(input logic [EXP_W-1:0] e,
                                    input logic [SAMPLE_WIDTH-1:0] a);
    logic [CMP_W-1:0] ew;
    logic [CMP_W-1:0] aw;
    ew = CMP_W'(e);
    aw = CMP_W'(a);
    return (a != '0) &&
           (ew * CMP_W'(RATIO_LO_E) > aw * CMP_W'(RATIO_LO_A)) &&
           (ew * CMP_W'(RATIO_HI_E) < aw * CMP_W'(RATIO_HI_A));
  endfunction

endpackage

`default_nettype wire

FILE: sv/mscal_regs.sv
// Configuration register bank behind the APB-style port.
`default_nettype none

module mscal_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mscal_pkg::APB_AW-1:0]   paddr,
  input  wire logic [mscal_pkg::APB_DW-1:0]   pwdata,
  output logic      [mscal_pkg::APB_DW-1:0]   prdata,
  output logic                                pready,
  output mscal_pkg::cfg_t                     cfg_o
);
  import mscal_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{exp_x: EXP_X_RST, exp_yz: EXP_YZ_RST, cal_samples: CAL_SMP_RST,
                 min_good: MIN_GOOD_RST, gain: GAIN_RST};
    end else if (wr_en) begin
      case (reg_idx)
        REG_EXP_X:    cfg_q.exp_x       <= pwdata[EXP_W-1:0];
        REG_EXP_YZ:   cfg_q.exp_yz      <= pwdata[EXP_W-1:0];
        REG_CAL_SMP:  cfg_q.cal_samples <= pwdata[CNT_W-1:0];
        REG_MIN_GOOD: cfg_q.min_good    <= pwdata[CNT_W-1:0];
        REG_GAIN:     cfg_q.gain        <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_EXP_X:    prdata = APB_DW'(cfg_q.exp_x);
      REG_EXP_YZ:   prdata = APB_DW'(cfg_q.exp_yz);
      REG_CAL_SMP:  prdata = APB_DW'(cfg_q.cal_samples);
      REG_MIN_GOOD: prdata = APB_DW'(cfg_q.min_good);
      REG_GAIN:     prdata = APB_DW'(cfg_q.gain);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/mscal_div.sv
// Shared restoring divider, two quotient bits per cycle.
`default_nettype none

module mscal_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [mscal_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  wire logic [mscal_pkg::SAMPLE_WIDTH-1:0] divisor_i,
  output logic                                   done_o,
  output logic      [mscal_pkg::QUOT_W-1:0]      quot_o
);
  import mscal_pkg::*;

  localparam int REM_W    = SAMPLE_WIDTH + 1;
  localparam int CNT_BITS = $clog2(DIV_STEPS + 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [QUOT_W-1:0]       quo_q, quo_d;
  logic [SAMPLE_WIDTH-1:0] divisor_q;

  assign done_o = done_q;
  assign quot_o = quo_q;

  // Two shift-and-subtract steps. The caller guarantees that the quotient fits
  // QUOT_W bits, so the dividend bits above it start out below the divisor.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      rem_d = {rem_d[REM_W-2:0], quo_d[QUOT_W-1]};
      quo_d = {quo_d[QUOT_W-2:0], 1'b0};
      if (rem_d >= {1'b0, divisor_q}) begin
        rem_d    = rem_d - {1'b0, divisor_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_BITS'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= REM_W'(dividend_i[DIVIDEND_W-1:QUOT_W]);
      quo_q     <= dividend_i[QUOT_W-1:0];
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

`ifndef SYNTHESIS
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_busy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0)) else $error("divider busy with empty step count");
`endif

endmodule

`default_nettype wire

FILE: sv/mscal_mul.sv
// Shared multiplier for field scaling: magnitude times scale, times gain, then round and clip.
`default_nettype none

module mscal_mul (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [mscal_pkg::SAMPLE_WIDTH-1:0] mag_i,
  input  wire logic                               neg_i,
  input  wire logic [mscal_pkg::SCALE_W-1:0]      scale_i,
  input  wire logic [mscal_pkg::GAIN_W-1:0]       gain_i,
  output logic                                    done_o,
  output logic      [mscal_pkg::FIELD_W-1:0]      field_o
);
  import mscal_pkg::*;

  localparam int PROD1_W = SAMPLE_WIDTH + SCALE_W;
  localparam int MULB_W  = (SCALE_W > GAIN_W) ? SCALE_W : GAIN_W;
  localparam int PROD_W  = PROD1_W + GAIN_W;
  localparam int RND_SH  = SCALE_FRAC_BITS + GAIN_FRAC_BITS - FIELD_FRAC_BITS;
  localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (RND_SH - 1);
  localparam logic [PROD_W:0] POS_LIM  = (PROD_W + 1)'((1 << (FIELD_W - 1)) - 1);
  localparam logic [PROD_W:0] NEG_LIM  = (PROD_W + 1)'(1 << (FIELD_W - 1));

  logic                      st1_q, st2_q, done_q;
  logic                      neg_q;
  logic [PROD_W-1:0]         prod_q;
  logic [FIELD_W-1:0]        field_q, field_d;
  logic [PROD1_W-1:0]        op_a;
  logic [MULB_W-1:0]         op_b;
  logic [PROD1_W+MULB_W-1:0] mul_res;
  logic [PROD_W:0]           rnd;
  logic [PROD_W:0]           mag_q;

  assign done_o  = done_q;
  assign field_o = field_q;

  // One multiplier, used first for the scale and then for the gain.
  always_comb begin
    op_a    = st1_q ? prod_q[PROD1_W-1:0] : PROD1_W'(mag_i);
    op_b    = st1_q ? MULB_W'(gain_i) : MULB_W'(scale_i);
    mul_res = op_a * op_b;
  end

  // Round half away from zero on the magnitude, then clip to the signed field range.
  always_comb begin
    rnd   = {1'b0, prod_q} + RND_HALF;
    mag_q = rnd >> RND_SH;
    if (neg_q) begin
      field_d = (mag_q > NEG_LIM) ? {1'b1, {(FIELD_W - 1){1'b0}}}
                                  : {FIELD_W{1'b0}} - mag_q[FIELD_W-1:0];
    end else begin
      field_d = (mag_q > POS_LIM) ? {1'b0, {(FIELD_W - 1){1'b1}}}
                                  : mag_q[FIELD_W-1:0];
    end
  end

  // Stage sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_q  <= 1'b0;
      st2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      st1_q  <= start_i;
      st2_q  <= st1_q;
      done_q <= st2_q;
    end
  end

  // Product and result registers.
  always_ff @(posedge clk_i) begin
    if (start_i || st1_q) begin
      prod_q <= mul_res[PROD_W-1:0];
    end
    if (start_i) begin
      neg_q <= neg_i;
    end
    if (st2_q) begin
      field_q <= field_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/magnetometer_scale_calibrator_unit.sv
// Top level of the magnetometer scale calibrator: stream ports, sequencer and calibration state.
// Work per item: a start item and a rejected calibration report run no ratio division; an
// accepted one runs three ratio divisions on the shared divider, and a report that closes
// a run also has the three averages divided out when enough good reports were taken.
// A good report outside calibration takes three passes of the shared multiplier.
// One item is in work at a time; the next is taken once the result sits in the output register.
// Reset is asynchronous and active low; it restores register defaults and unity scales.
`default_nettype none

module magnetometer_scale_calibrator_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input beat.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [mscal_pkg::S_TDATA_W-1:0] s_tdata,  // sample_x, sample_y, sample_z
  input  wire logic [mscal_pkg::S_TUSER_W-1:0] s_tuser,  // kind, read_ok
  // Output beat.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [mscal_pkg::M_TDATA_W-1:0] m_tdata,  // field_x, field_y, field_z, zero pad
  output logic      [mscal_pkg::M_TUSER_W-1:0] m_tuser,  // calibrating, field_valid,
                                                          // used_unity_scale
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mscal_pkg::APB_AW-1:0]    paddr,
  input  wire logic [mscal_pkg::APB_DW-1:0]    pwdata,
  output logic      [mscal_pkg::APB_DW-1:0]    prdata,
  output logic                                 pready
);
  import mscal_pkg::*;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  cfg_t   cfg;
  state_e state_q, state_d;

  // Sequencer controls.
  logic s_accept, div_start, mul_start, out_load;
  logic all_ok, avg_ok, last_axis, run_ends;

  // Item registers.
  logic                    kind_q, ok_q;
  logic [SAMPLE_WIDTH-1:0] mag_q [3];
  logic                    neg_q [3];

  // Calibration state.
  logic [CNT_W-1:0]   samples_left_q, good_q;
  logic [SUM_W-1:0]   sum_q   [3];
  logic [SCALE_W-1:0] scale_q [3];
  logic               unity_q;
  logic [1:0]         axis_q;
  logic               div_avg_q;
  logic               valid_q;
  logic [FIELD_W-1:0] field_q [3];

  // Output register.
  logic                 m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TUSER_W-1:0] m_tuser_q;

  // Shared units.
  logic [DIVIDEND_W-1:0]   div_dividend;
  logic [SAMPLE_WIDTH-1:0] div_divisor;
  logic [EXP_W-1:0]        exp_sel;
  logic                    div_done, mul_done;
  logic [QUOT_W-1:0]       div_quot;
  logic [FIELD_W-1:0]      mul_field;

  mscal_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Divider operands: a ratio e << F / |r|, or an average sum / good count.
  always_comb begin
    exp_sel      = (axis_q == AXIS_X) ? cfg.exp_x : cfg.exp_yz;
    div_dividend = div_avg_q ? DIVIDEND_W'(sum_q[axis_q])
                             : {exp_sel, {SCALE_FRAC_BITS{1'b0}}};
    div_divisor  = div_avg_q ? SAMPLE_WIDTH'(good_q) : mag_q[axis_q];
  end

  mscal_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  mscal_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mag_i   (mag_q[axis_q]),
    .neg_i   (neg_q[axis_q]),
    .scale_i (scale_q[axis_q]),
    .gain_i  (cfg.gain),
    .done_o  (mul_done),
    .field_o (mul_field)
  );

  // Decision terms.
  assign all_ok = ratio_ok(cfg.exp_x, mag_q[0]) && ratio_ok(cfg.exp_yz, mag_q[1]) &&
                  ratio_ok(cfg.exp_yz, mag_q[2]);
  assign avg_ok    = (good_q != '0) && (good_q >= cfg.min_good);
  assign last_axis = (axis_q == AXIS_LAST);
  assign run_ends  = (samples_left_q == CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!kind_q) begin
          state_d = (cfg.cal_samples == '0) ? ST_FINISH : ST_RESULT;
        end else if (samples_left_q != '0) begin
          if (ok_q && all_ok) state_d = ST_DIV_GO;
          else                state_d = run_ends ? ST_FINISH : ST_RESULT;
        end else begin
          state_d = ok_q ? ST_MUL_GO : ST_RESULT;
        end
      end
      ST_FINISH:   state_d = avg_ok ? ST_DIV_GO : ST_RESULT;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (!last_axis)     state_d = ST_DIV_GO;
          else if (div_avg_q) state_d = ST_RESULT;
          else                state_d = run_ends ? ST_FINISH : ST_RESULT;
        end
      end
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) state_d = last_axis ? ST_RESULT : ST_MUL_GO;
      end
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready  = (state_q == ST_IDLE);
    div_start = (state_q == ST_DIV_GO);
    mul_start = (state_q == ST_MUL_GO);
    out_load  = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);
  end

  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Calibration state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_left_q <= '0;
      good_q         <= '0;
      unity_q        <= 1'b1;
      axis_q         <= AXIS_X;
      div_avg_q      <= 1'b0;
      valid_q        <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]   <= '0;
        scale_q[i] <= SCALE_ONE;
      end
    end else begin
      case (state_q)
        ST_DECODE: begin
          axis_q    <= AXIS_X;
          div_avg_q <= 1'b0;
          valid_q   <= 1'b0;
          if (!kind_q) begin
            samples_left_q <= cfg.cal_samples;
            good_q         <= '0;
            for (int i = 0; i < 3; i++) begin
              sum_q[i] <= '0;
            end
          end else if (samples_left_q != '0) begin
            if (!(ok_q && all_ok)) samples_left_q <= samples_left_q - 1'b1;
          end else begin
            valid_q <= ok_q;
          end
        end
        ST_FINISH: begin
          axis_q <= AXIS_X;
          if (avg_ok) begin
            div_avg_q <= 1'b1;
          end else begin
            unity_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              scale_q[i] <= SCALE_ONE;
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            axis_q <= axis_q + 1'b1;
            if (div_avg_q) begin
              scale_q[axis_q] <= div_quot;
              if (last_axis) unity_q <= 1'b0;
            end else begin
              sum_q[axis_q] <= sum_q[axis_q] + SUM_W'(div_quot);
              if (last_axis) begin
                if (good_q != '1) good_q <= good_q + 1'b1;
                samples_left_q <= samples_left_q - 1'b1;
              end
            end
          end
        end
        ST_MUL_WAIT: begin
          if (mul_done) axis_q <= axis_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Item capture and scaled fields.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q <= s_tuser[0];
      ok_q   <= s_tuser[1];
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= sample_mag(s_tdata[i*IN_SAMPLE_W +: IN_SAMPLE_W]);
        neg_q[i] <= s_tdata[i*IN_SAMPLE_W + SAMPLE_WIDTH - 1];
      end
    end
    if (state_q == ST_DECODE) begin
      for (int i = 0; i < 3; i++) begin
        field_q[i] <= '0;
      end
    end else if ((state_q == ST_MUL_WAIT) && mul_done) begin
      field_q[axis_q] <= mul_field;
    end
  end

  // Output register: holds one result beat while the next item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= {{OUT_PAD_W{1'b0}}, field_q[2], field_q[1], field_q[0]};
      m_tuser_q <= {unity_q, valid_q, (samples_left_q != '0)};
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;
  assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
  a_invalid_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RESULT) && !valid_q) |->
      ((field_q[0] == '0) && (field_q[1] == '0) && (field_q[2] == '0)))
    else $error("fields not cleared for a result without a good report");
  a_unity_scales : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && unity_q) |->
      ((scale_q[0] == SCALE_ONE) && (scale_q[1] == SCALE_ONE) && (scale_q[2] == SCALE_ONE)))
    else $error("unity flag set with a non-unity scale");
  a_mul_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_WAIT))
    else $error("multiplier result outside its wait state");
`endif

endmodule

`default_nettype wire
